// ===== sv/rlwe_dec_pkg.sv =====
`timescale 1ns / 1ps
package rlwe_dec_pkg;

  // Ring size and number of mask/key polynomial pairs.
  localparam int POLY_DEGREE = 1024;
  localparam int MASK_COUNT  = 1;
  localparam int STORE_DEPTH = MASK_COUNT * POLY_DEGREE;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_MASK  = 2'd1,
    KIND_BODY  = 2'd2,
    KIND_START = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  component;
    logic [11:0] coef_index;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  word_index;
    logic [63:0] bits;
    logic        last_word;
  } out_item_t;

endpackage

// ===== sv/ring_lwe_sign_decrypt.sv =====
`timescale 1ns / 1ps
// Ring-LWE symmetric decryption to sign bits. Load items write one 64-bit
// coefficient of a key, mask or body polynomial each.
// A start item computes body minus the negacyclic products of the mask and
// key polynomials and returns one item per 64 phase coefficients. The
// product runs through a single multiply-accumulate fed by the key and mask
// memories, one coefficient pair per cycle. No input item is taken while
// a start item runs. Every store entry must be loaded before a start.
module ring_lwe_sign_decrypt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  rlwe_dec_pkg::in_item_t  in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rlwe_dec_pkg::out_item_t out_item_o
);
  import rlwe_dec_pkg::*;

  localparam int CW = $clog2(POLY_DEGREE);
  localparam int SW = $clog2(STORE_DEPTH);
  localparam int KW = (MASK_COUNT > 1) ? $clog2(MASK_COUNT) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [KW-1:0] k_q, k_d;
  logic [63:0]   acc_q, acc_d;
  logic [63:0]   bits_q, bits_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  // Memories.
  logic [63:0] key_mem  [STORE_DEPTH];
  logic [63:0] mask_mem [STORE_DEPTH];
  logic [63:0] body_mem [POLY_DEGREE];
  logic [63:0] key_rd_q, mask_rd_q, body_rd_q;

  logic          in_acc;
  logic [15:0]   load_full;
  logic [SW-1:0] load_addr;
  logic          idx_ok, comp_ok;
  logic          key_we, mask_we, body_we;
  logic [CW:0]   kidx;
  logic [15:0]   mask_full, key_full;
  logic [SW-1:0] mask_ra, key_ra;

  // Pipeline registers.
  logic        v1_q, n1_q, v2_q, n2_q;
  logic [63:0] pll_q;
  logic [31:0] pcross_q;
  logic [31:0] plh, phl;
  logic [63:0] prod;
  logic [63:0] phase;
  logic        pos_bit, emit, last_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Load address decode.
  assign load_full = 16'(in_item_i.component) * 16'(POLY_DEGREE) + 16'(in_item_i.coef_index);
  assign load_addr = load_full[SW-1:0];
  assign idx_ok    = 13'(in_item_i.coef_index) < 13'(POLY_DEGREE);
  assign comp_ok   = 3'(in_item_i.component) < 3'(MASK_COUNT);
  assign key_we    = in_acc && idx_ok && comp_ok && (in_item_i.kind == KIND_KEY);
  assign mask_we   = in_acc && idx_ok && comp_ok && (in_item_i.kind == KIND_MASK);
  assign body_we   = in_acc && idx_ok && (in_item_i.kind == KIND_BODY);

  // Negacyclic read addresses: key index is (i - j) mod N.
  assign kidx = (j_q <= i_q) ? ({1'b0, i_q} - {1'b0, j_q})
                             : ({1'b0, i_q} + (CW+1)'(POLY_DEGREE) - {1'b0, j_q});
  assign mask_full = 16'(k_q) * 16'(POLY_DEGREE) + 16'(j_q);
  assign key_full  = 16'(k_q) * 16'(POLY_DEGREE) + 16'(kidx[CW-1:0]);
  assign mask_ra   = mask_full[SW-1:0];
  assign key_ra    = key_full[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[load_addr] <= in_item_i.value;
    end
    key_rd_q <= key_mem[key_ra];
  end

  always_ff @(posedge clk_i) begin
    if (mask_we) begin
      mask_mem[load_addr] <= in_item_i.value;
    end
    mask_rd_q <= mask_mem[mask_ra];
  end

  always_ff @(posedge clk_i) begin
    if (body_we) begin
      body_mem[in_item_i.coef_index[CW-1:0]] <= in_item_i.value;
    end
    body_rd_q <= body_mem[i_q];
  end

  // Low 64 bits of the 64x64 product from three 32x32 partial products.
  // Only the low half of each cross product reaches the result.
  assign plh = mask_rd_q[31:0] * key_rd_q[63:32];
  assign phl = mask_rd_q[63:32] * key_rd_q[31:0];

  always_ff @(posedge clk_i) begin
    pll_q    <= 64'(mask_rd_q[31:0]) * 64'(key_rd_q[31:0]);
    pcross_q <= plh + phl;
    n1_q     <= (j_q > i_q);
    n2_q     <= n1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= (state_q == S_RUN);
      v2_q <= v1_q;
    end
  end

  assign prod    = pll_q + {pcross_q, 32'b0};
  assign phase   = body_rd_q - acc_q;
  assign pos_bit = (phase != 64'd0) && !phase[63];
  assign last_i  = (i_q == CW'(POLY_DEGREE - 1));
  assign emit    = (i_q[5:0] == 6'd63) || last_i;

  // Sequencer over output coefficient i, polynomial k and term j.
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    acc_d       = acc_q;
    bits_d      = bits_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (v2_q) begin
      acc_d = n2_q ? (acc_q - prod) : (acc_q + prod);
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (in_item_i.kind == KIND_START)) begin
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          acc_d   = '0;
          bits_d  = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (j_q == CW'(POLY_DEGREE - 1)) begin
          j_d = '0;
          if (k_q == KW'(MASK_COUNT - 1)) begin
            k_d     = '0;
            state_d = S_DRAIN;
          end else begin
            k_d = k_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!(out_valid_q && out_stall_i)) begin
          bits_d = bits_q | (64'(pos_bit) << i_q[5:0]);
          if (emit) begin
            out_valid_d     = 1'b1;
            out_d.word_index = 6'(i_q >> 6);
            out_d.bits      = bits_d;
            out_d.last_word = last_i;
            bits_d          = '0;
          end
          acc_d = '0;
          if (last_i) begin
            i_d     = '0;
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_RUN;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    bits_q <= bits_d;
    out_q  <= out_d;
  end

  // The multiply pipeline is empty whenever a coefficient is finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> (!v1_q && !v2_q))
    else $error("multiply pipeline busy at finish");

  // No product is still in flight while the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !v2_q)
    else $error("product in flight while idle");

  // A pending result is never overwritten by the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("pending result overwritten");

endmodule
